>>> hw/rtl/atan_pkg.sv
// atan_pkg: formats, coefficients and cell data types for the arctangent pipeline
// no dependencies; used by every file of the block
`timescale 1ns / 1ps

package atan_pkg;

  localparam int IN_FRAC_BITS  = 16;
  localparam int OUT_FRAC_BITS = 29;

  localparam int X_W     = 32;
  localparam int ANGLE_W = 31;
  localparam int QF      = 30;
  localparam int Q_W     = 34;
  localparam int MAG_W   = 31;
  localparam int DIV_STEPS = QF + 1;
  localparam int NUM_W   = QF + IN_FRAC_BITS + 1;
  localparam int REM_W   = MAG_W;
  localparam int POLY_STAGES = 6;
  localparam int SH      = QF - OUT_FRAC_BITS;

  localparam logic signed [Q_W-1:0] C0 = -34'sd20234667;
  localparam logic signed [Q_W-1:0] C1 =  34'sd75165532;
  localparam logic signed [Q_W-1:0] C2 = -34'sd140906329;
  localparam logic signed [Q_W-1:0] C3 =  34'sd213415983;
  localparam logic signed [Q_W-1:0] C4 = -34'sd357890713;
  localparam logic signed [Q_W-1:0] HALF_PI_Q = 34'sd1686629713;

  localparam longint RND_ADD = (SH > 0) ? (64'sd1 <<< (SH - 1)) : 64'sd0;
  localparam longint LIM_L   = (64'sd1686629713 + RND_ADD) >>> SH;
  localparam logic [Q_W-1:0] ANGLE_LIM = Q_W'(LIM_L);
  localparam logic [Q_W-1:0] RND_Q     = Q_W'(RND_ADD);

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [DIV_STEPS-1:0] num;
    logic [DIV_STEPS-1:0] quo;
    logic [MAG_W-1:0]     mag;
    logic                 neg;
    logic                 reduced;
  } div_t;

  typedef struct packed {
    logic signed [Q_W-1:0] m;
    logic                  neg;
    logic                  reduced;
  } side_t;

endpackage

>>> hw/rtl/atan_in_if.sv
// atan_in_if: argument channel, valid/ready with the x_value word
// depends on atan_pkg
`timescale 1ns / 1ps

interface atan_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [atan_pkg::X_W-1:0]    x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

>>> hw/rtl/atan_out_if.sv
// atan_out_if: result channel, valid/ready with the angle word
// depends on atan_pkg
`timescale 1ns / 1ps

interface atan_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [atan_pkg::ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

>>> hw/rtl/atan_div_cell.sv
// atan_div_cell: one restoring division step of the reciprocal chain
// depends on atan_pkg
`timescale 1ns / 1ps

module atan_div_cell (
  input  logic            clk,
  input  logic            en,
  input  atan_pkg::div_t  d_in,
  output atan_pkg::div_t  d_out_r
);

  logic [atan_pkg::REM_W:0] trial;
  logic                     ge;
  atan_pkg::div_t           d_nxt;

  always_comb begin
    trial = {d_in.rem, d_in.num[atan_pkg::DIV_STEPS-1]};
    ge    = trial >= {1'b0, d_in.mag};
    d_nxt = d_in;
    d_nxt.rem = ge ? atan_pkg::REM_W'(trial - {1'b0, d_in.mag})
                   : trial[atan_pkg::REM_W-1:0];
    d_nxt.num = {d_in.num[atan_pkg::DIV_STEPS-2:0], 1'b0};
    d_nxt.quo = {d_in.quo[atan_pkg::DIV_STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out_r <= d_nxt;
    end
  end

endmodule

>>> hw/rtl/atan_mac_cell.sv
// atan_mac_cell: registered fixed-point multiply-add, product >> 30 rounded to nearest, ties away from zero
// depends on atan_pkg
`timescale 1ns / 1ps

module atan_mac_cell (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [atan_pkg::Q_W-1:0] a,
  input  logic signed [atan_pkg::Q_W-1:0] b,
  input  logic signed [atan_pkg::Q_W-1:0] c,
  output logic signed [atan_pkg::Q_W-1:0] y_r
);

  logic signed [2*atan_pkg::Q_W-1:0] prod;
  logic        [2*atan_pkg::Q_W-1:0] pabs;
  logic        [2*atan_pkg::Q_W-1:0] rnd;
  logic signed [atan_pkg::Q_W-1:0]   q;
  logic signed [atan_pkg::Q_W-1:0]   y_nxt;

  always_comb begin
    prod  = a * b;
    pabs  = prod[2*atan_pkg::Q_W-1] ? (2*atan_pkg::Q_W)'(-prod) : prod;
    rnd   = (pabs + ((2*atan_pkg::Q_W)'(1) << (atan_pkg::QF - 1))) >> atan_pkg::QF;
    q     = prod[2*atan_pkg::Q_W-1] ? -$signed(rnd[atan_pkg::Q_W-1:0])
                                    : $signed(rnd[atan_pkg::Q_W-1:0]);
    y_nxt = q + c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

endmodule

>>> hw/rtl/arctangent_poly_approx.sv
// arctangent_poly_approx: top level, reciprocal division chain then Horner multiply-add cells
// depends on atan_pkg, atan_in_if, atan_out_if, atan_div_cell, atan_mac_cell
`timescale 1ns / 1ps

// Takes one Q16.16 argument per cycle and returns its arctangent in Q2.29
// radians, saturated to +-pi/2. The block is a pipeline of 39 stages: one
// input stage, a chain of 31 division cells (one quotient bit each) that
// forms the reciprocal for arguments of magnitude one or more, the
// multiply-add cells for the odd polynomial, and the output register.
// Throughput is one word per cycle; the whole pipeline holds when the
// output word is not taken.

module arctangent_poly_approx (
  input  logic              clk,
  input  logic              rst_n,
  atan_in_if.sink           in_ch,
  atan_out_if.source        out_ch
);

  localparam int NST = 1 + atan_pkg::DIV_STEPS + atan_pkg::POLY_STAGES;

  logic                                adv;
  logic [NST-1:0]                      vld_r;
  logic                                out_valid_r;
  logic signed [atan_pkg::ANGLE_W-1:0] out_angle_r;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.angle = out_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NST-2:0], in_ch.valid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  // input stage: magnitude, saturation and division setup
  logic [atan_pkg::X_W-1:0]   raw;
  logic [atan_pkg::X_W-1:0]   mag_full;
  logic [atan_pkg::MAG_W-1:0] mag;
  logic [atan_pkg::NUM_W-1:0] numer;
  atan_pkg::div_t             d0_nxt;
  atan_pkg::div_t             div_r [0:atan_pkg::DIV_STEPS];

  always_comb begin
    raw      = in_ch.x_value;
    mag_full = raw[atan_pkg::X_W-1] ? atan_pkg::X_W'(-raw) : raw;
    mag      = mag_full[atan_pkg::X_W-1] ? {atan_pkg::MAG_W{1'b1}}
                                         : mag_full[atan_pkg::MAG_W-1:0];
    numer    = (atan_pkg::NUM_W'(1) << (atan_pkg::NUM_W - 1))
             + atan_pkg::NUM_W'(mag >> 1);
    d0_nxt.rem = atan_pkg::REM_W'(numer[atan_pkg::NUM_W-1:atan_pkg::DIV_STEPS]);
    d0_nxt.num = numer[atan_pkg::DIV_STEPS-1:0];
    d0_nxt.quo = '0;
    d0_nxt.mag = mag;
    d0_nxt.neg = raw[atan_pkg::X_W-1];
    d0_nxt.reduced = mag >= (atan_pkg::MAG_W'(1) << atan_pkg::IN_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0] <= d0_nxt;
    end
  end

  for (genvar i = 0; i < atan_pkg::DIV_STEPS; i++) begin : g_div
    atan_div_cell u_cell (
      .clk     (clk),
      .en      (adv),
      .d_in    (div_r[i]),
      .d_out_r (div_r[i+1])
    );
  end

  // reduced value m in Q1.30
  atan_pkg::div_t dq;
  atan_pkg::side_t side0;

  always_comb begin
    dq = div_r[atan_pkg::DIV_STEPS];
    side0.m = dq.reduced
      ? $signed({{(atan_pkg::Q_W-atan_pkg::DIV_STEPS){1'b0}}, dq.quo})
      : $signed(atan_pkg::Q_W'(dq.mag) << (atan_pkg::QF - atan_pkg::IN_FRAC_BITS));
    side0.neg     = dq.neg;
    side0.reduced = dq.reduced;
  end

  atan_pkg::side_t side_r [1:atan_pkg::POLY_STAGES];
  logic signed [atan_pkg::Q_W-1:0] s1_r, s2_r, s3_r, s4_r, t3_r, t4_r, t5_r, t6_r;
  logic signed [atan_pkg::Q_W-1:0] s_c, p1_c, t_c, p2_c, p3_c, p4_c, v_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[1] <= side0;
      for (int k = 2; k <= atan_pkg::POLY_STAGES; k++) begin
        side_r[k] <= side_r[k-1];
      end
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
      t4_r <= t3_r;
      t5_r <= t4_r;
      t6_r <= t5_r;
    end
  end

  assign s1_r = s_c;
  assign t3_r = t_c;

  atan_mac_cell u_sq (.clk(clk), .en(adv), .a(side0.m), .b(side0.m),
                      .c('0), .y_r(s_c));
  atan_mac_cell u_h1 (.clk(clk), .en(adv), .a(atan_pkg::C0), .b(s1_r),
                      .c(atan_pkg::C1), .y_r(p1_c));
  atan_mac_cell u_ms (.clk(clk), .en(adv), .a(side_r[1].m), .b(s1_r),
                      .c('0), .y_r(t_c));
  atan_mac_cell u_h2 (.clk(clk), .en(adv), .a(p1_c), .b(s2_r),
                      .c(atan_pkg::C2), .y_r(p2_c));
  atan_mac_cell u_h3 (.clk(clk), .en(adv), .a(p2_c), .b(s3_r),
                      .c(atan_pkg::C3), .y_r(p3_c));
  atan_mac_cell u_h4 (.clk(clk), .en(adv), .a(p3_c), .b(s4_r),
                      .c(atan_pkg::C4), .y_r(p4_c));
  atan_mac_cell u_fin (.clk(clk), .en(adv), .a(t6_r), .b(p4_c),
                       .c(side_r[5].m), .y_r(v_c));

  // reflect, clamp, round to output format and restore sign
  logic signed [atan_pkg::Q_W-1:0] vr;
  logic        [atan_pkg::Q_W-1:0] uv;
  logic signed [atan_pkg::ANGLE_W-1:0] out_angle_nxt;

  always_comb begin
    vr = side_r[6].reduced ? atan_pkg::HALF_PI_Q - v_c : v_c;
    if (vr < 0) begin
      vr = '0;
    end
    uv = (atan_pkg::Q_W'(vr) + atan_pkg::RND_Q) >> atan_pkg::SH;
    if (uv > atan_pkg::ANGLE_LIM) begin
      uv = atan_pkg::ANGLE_LIM;
    end
    out_angle_nxt = side_r[6].neg ? atan_pkg::ANGLE_W'(-uv)
                                  : atan_pkg::ANGLE_W'(uv);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_angle_r <= out_angle_nxt;
    end
  end

endmodule

>>> hw/rtl/atan_chk.sv
// atan_chk: port-level checks for arctangent_poly_approx, attached by bind
// depends on atan_pkg
`timescale 1ns / 1ps

module atan_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [atan_pkg::ANGLE_W-1:0] out_angle
);

  localparam logic signed [atan_pkg::ANGLE_W-1:0] LIM =
    $signed(atan_pkg::ANGLE_W'(atan_pkg::ANGLE_LIM));

  // pending word is never dropped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle <= LIM) && (out_angle >= -LIM))
    else $error("angle outside +-pi/2");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a free output never stalls the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output free");

  a_nostall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind arctangent_poly_approx atan_chk u_atan_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_angle (out_ch.angle)
);
